// ===== design/seven_segment_frame_formatter_unit_assert.svh =====
// Assertion macros for the frame formatter modules; ssff_back includes them.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef SEVEN_SEGMENT_FRAME_FORMATTER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_FRAME_FORMATTER_UNIT_ASSERT_SVH

// Checks that a consequence holds in the same cycle as its condition.
`define SSFF_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Checks that a consequence holds in the cycle after its condition.
`define SSFF_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== design/ssff_pkg.sv =====
// Shared types, codes and the segment table for the frame formatter.
// No dependencies; used by the front end, the queue and the serializer.
package ssff_pkg;

  // Display positions that any mode can write (positions 0 to 4).
  localparam int NUM_POS = 5;
  localparam int POS_W   = 3;

  typedef logic [7:0] seg_t;
  typedef logic [NUM_POS-1:0][7:0] seg_buf_t;

  // Request modes.
  localparam logic [1:0] FUNC_INT  = 2'd0;
  localparam logic [1:0] FUNC_HEX  = 2'd1;
  localparam logic [1:0] FUNC_TIME = 2'd2;
  localparam logic [1:0] FUNC_DATE = 2'd3;

  // Character codes: 0 to 15 are hex digit values, the rest are symbols.
  localparam logic [4:0] CH_BLANK = 5'd16;
  localparam logic [4:0] CH_MINUS = 5'd17;
  localparam logic [4:0] CH_COLON = 5'd18;

  // Segment patterns for symbols.
  localparam seg_t SEG_BLANK = 8'h00;
  localparam seg_t SEG_DOT   = 8'h80;
  localparam seg_t SEG_COLON = 8'h03;
  localparam seg_t SEG_MINUS = 8'h40;

  // Segment patterns for the hex digits 0 to F.
  localparam seg_t HEX_SEG [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // Maps a character code to its segment pattern; unknown codes are blank.
  function automatic seg_t seg_of_char(input logic [4:0] c);
    seg_t s;
    if (!c[4]) begin
      s = HEX_SEG[c[3:0]];
    end else begin
      case (c)
        CH_MINUS: s = SEG_MINUS;
        CH_COLON: s = SEG_COLON;
        default:  s = SEG_BLANK;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== design/ssff_front.sv =====
// Front end: accepts requests, decodes the mode and builds the segment buffer.
// Uses ssff_pkg; integer mode runs a multi-cycle binary to BCD converter.
module ssff_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               colon_layout,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_number,
  input  logic [7:0]         in_first_pair,
  input  logic [7:0]         in_second_pair,
  output logic               res_valid,
  input  logic               res_ready,
  output ssff_pkg::seg_buf_t res_data
);
  import ssff_pkg::*;

  // Four magnitude bits are shifted into the BCD digits per cycle.
  localparam logic [3:0] CONV_STEPS = 4'd8;

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic        neg_r;
  logic [71:0] dd_r;
  logic        res_valid_r;
  seg_buf_t    res_r;

  logic        accept;
  logic [31:0] num_u;
  logic [31:0] mag;
  logic [3:0][7:0] hex_segs;
  logic [15:0] prod_a;
  logic [15:0] prod_b;
  logic [4:0]  tens_a;
  logic [4:0]  tens_b;
  logic [7:0]  rem_a;
  logic [7:0]  rem_b;
  seg_buf_t    direct_buf;

  // Places four characters, skipping position 2 when a colon digit exists.
  function automatic seg_buf_t place_four(input logic [3:0][7:0] s, input logic colon);
    seg_buf_t b;
    b = '0;
    b[0] = s[0];
    b[1] = s[1];
    if (colon) begin
      b[3] = s[2];
      b[4] = s[3];
    end else begin
      b[2] = s[2];
      b[3] = s[3];
    end
    return b;
  endfunction

  // Places two digit pairs with a colon or with dots between them.
  function automatic seg_buf_t place_pairs(input seg_t ta, input seg_t ua, input seg_t tb,
                                           input seg_t ub, input logic date,
                                           input logic colon);
    seg_buf_t b;
    b = '0;
    b[0] = ta;
    if (colon) begin
      b[1] = ua | (date ? SEG_DOT : SEG_BLANK);
      b[2] = date ? SEG_DOT : SEG_COLON;
      b[3] = tb;
      b[4] = ub;
    end else begin
      b[1] = ua | (date ? SEG_DOT : SEG_COLON);
      b[2] = tb;
      b[3] = ub;
    end
    return b;
  endfunction

  // Tens of a pair value above 99 land on a colon, a hex letter or a blank.
  function automatic logic [4:0] pair_tens_char(input logic [4:0] tens);
    logic [4:0] c;
    if (tens < 5'd10) begin
      c = tens;
    end else if (tens == 5'd10) begin
      c = CH_COLON;
    end else if (tens >= 5'd17 && tens <= 5'd22) begin
      c = tens - 5'd7;
    end else begin
      c = CH_BLANK;
    end
    return c;
  endfunction

  // One converter cycle: four add-3-and-shift steps over ten BCD digits.
  function automatic logic [71:0] dabble4(input logic [71:0] v);
    logic [71:0] t;
    t = v;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 10; d++) begin
        if (t[32+4*d +: 4] >= 4'd5) begin
          t[32+4*d +: 4] = t[32+4*d +: 4] + 4'd3;
        end
      end
      t = {t[70:0], 1'b0};
    end
    return t;
  endfunction

  // Builds the right-justified four-character integer field from BCD digits.
  function automatic seg_buf_t compose_int(input logic [9:0][3:0] bcd, input logic neg,
                                           input logic colon);
    logic [3:0]      nd;
    logic [3:0]      len;
    logic [2:0]      pad;
    logic [2:0]      t;
    logic [2:0]      k;
    logic [3:0]      di;
    logic [4:0]      ch;
    logic [3:0][7:0] s;
    nd = 4'd1;
    for (int d = 0; d < 10; d++) begin
      if (bcd[d] != 4'd0) begin
        nd = 4'(d + 1);
      end
    end
    len = nd + {3'b0, neg};
    pad = (len < 4'd4) ? 3'(4'd4 - len) : 3'd0;
    for (int i = 0; i < 4; i++) begin
      t  = 3'(i) - pad;
      k  = t - {2'b0, neg};
      di = nd - 4'd1 - {1'b0, k};
      if (3'(i) < pad) begin
        ch = CH_BLANK;
      end else if (neg && t == 3'd0) begin
        ch = CH_MINUS;
      end else begin
        ch = {1'b0, bcd[di]};
      end
      s[i] = seg_of_char(ch);
    end
    return place_four(s, colon);
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = !busy_r && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res_data  = res_r;

  // Magnitude of the integer value.
  assign num_u = in_number;
  assign mag   = num_u[31] ? (32'd0 - num_u) : num_u;

  // Pair split by reciprocal multiply: v / 10 equals (v * 205) >> 11 for 8 bits.
  always_comb begin
    prod_a = {8'b0, in_first_pair} * 16'd205;
    prod_b = {8'b0, in_second_pair} * 16'd205;
    tens_a = prod_a[15:11];
    tens_b = prod_b[15:11];
    rem_a  = in_first_pair - 8'({3'b0, tens_a} * 8'd10);
    rem_b  = in_second_pair - 8'({3'b0, tens_b} * 8'd10);
  end

  // Hex digits, most significant nibble first.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hex_segs[i] = seg_of_char({1'b0, in_number[4*(3-i) +: 4]});
    end
  end

  // Hex, time and date modes build their buffer directly.
  always_comb begin
    case (in_func)
      FUNC_HEX: direct_buf = place_four(hex_segs, colon_layout);
      FUNC_TIME: direct_buf = place_pairs(seg_of_char(pair_tens_char(tens_a)),
                                          seg_of_char({1'b0, rem_a[3:0]}),
                                          seg_of_char(pair_tens_char(tens_b)),
                                          seg_of_char({1'b0, rem_b[3:0]}),
                                          1'b0, colon_layout);
      FUNC_DATE: direct_buf = place_pairs(seg_of_char(pair_tens_char(tens_a)),
                                          seg_of_char({1'b0, rem_a[3:0]}),
                                          seg_of_char(pair_tens_char(tens_b)),
                                          seg_of_char({1'b0, rem_b[3:0]}),
                                          1'b1, colon_layout);
      default: direct_buf = '0;
    endcase
  end

  // Control: converter busy flag, step counter and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 4'd0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_func == FUNC_INT) begin
          busy_r <= 1'b1;
          cnt_r  <= 4'd0;
        end else begin
          res_valid_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == CONV_STEPS) begin
          busy_r      <= 1'b0;
          res_valid_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  // Datapath: converter shift register and the finished buffer.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= num_u[31];
      dd_r  <= {40'b0, mag};
      if (in_func != FUNC_INT) begin
        res_r <= direct_buf;
      end
    end else if (busy_r) begin
      if (cnt_r == CONV_STEPS) begin
        res_r <= compose_int(dd_r[71:32], neg_r, colon_layout);
      end else begin
        dd_r <= dabble4(dd_r);
      end
    end
  end

endmodule

// ===== design/ssff_fifo.sv =====
// Two-entry queue of segment buffers between the front end and the serializer.
// Uses ssff_pkg for the buffer type.
module ssff_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  ssff_pkg::seg_buf_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output ssff_pkg::seg_buf_t rd_data
);
  import ssff_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  seg_buf_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != DEPTH);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/ssff_back.sv =====
// Serializer: turns one segment buffer into the address, segment and zero bytes.
// Uses ssff_pkg and the assertion macros header.
`include "seven_segment_frame_formatter_unit_assert.svh"

module ssff_back #(
  parameter int DISPLAY_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  ssff_pkg::seg_buf_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_last
);
  import ssff_pkg::*;

  localparam int FRAME_LEN = 2 * DISPLAY_BYTES + 1;
  localparam int IW        = $clog2(FRAME_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);

  logic          out_valid_r;
  logic [IW-1:0] idx_r;
  seg_buf_t      cur_r;
  logic          pos_in_range;

  assign out_valid = out_valid_r;
  assign out_last  = (idx_r == LAST_IDX);
  assign q_ready   = !out_valid_r || (out_ready && out_last);

  // Odd bytes carry segment data; only the first positions can be nonzero.
  assign pos_in_range   = (idx_r[IW-1:1] < (IW-1)'(NUM_POS));
  assign out_frame_byte = (idx_r[0] && pos_in_range) ? cur_r[idx_r[POS_W:1]] : 8'h00;

  // Frame sequencing; the next buffer is taken as the last byte leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (q_ready && q_valid) begin
        out_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (out_valid_r && out_ready) begin
        if (out_last) begin
          out_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IW'(1);
        end
      end
    end
  end

  // Buffer being sent.
  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      cur_r <= q_data;
    end
  end

  // A frame runs without gaps, one byte after the other, and ends on a zero byte.
  `SSFF_ASSERT_NEXT(a_frame_no_gap, out_valid_r && out_ready && !out_last, out_valid_r,
    "frame dropped valid before its last byte")
  `SSFF_ASSERT_NEXT(a_frame_step, out_valid_r && out_ready && !out_last,
    idx_r == $past(idx_r) + IW'(1), "frame byte index did not advance by one")
  `SSFF_ASSERT_NOW(a_last_is_zero, out_valid_r && out_last, out_frame_byte == 8'h00,
    "last byte of a frame is not zero")

endmodule

// ===== design/seven_segment_frame_formatter_unit.sv =====
// Top level of the seven-segment frame formatter.
// Depends on ssff_pkg, ssff_front, ssff_fifo and ssff_back.

// Each accepted request (integer, hex, time or date) yields one display RAM frame
// of 2*DISPLAY_BYTES+1 bytes (17 by default): an address byte 0, then each
// segment byte followed by a zero byte, with out_last on the final byte. The
// serializer sends one byte per cycle while out_ready is high and, when a buffer
// is queued, starts the next frame in the cycle after the last byte. Hex, time
// and date requests are formatted directly; integer requests pass through a
// binary to BCD converter that holds the front end, which is hidden behind the
// serializer. A two-entry queue sits between formatter and serializer, so new
// requests are taken while a frame is still being sent. A formatted buffer
// passes through the front end's result register, the queue and the serializer's
// buffer register before its first byte leaves. colon_layout is written through
// the cfg port and should be changed only while no request is in flight.
module seven_segment_frame_formatter_unit #(
  parameter int DISPLAY_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_colon_layout,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_number,
  input  logic [7:0]         in_first_pair,
  input  logic [7:0]         in_second_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_last
);
  import ssff_pkg::*;

  logic     colon_layout_r;
  logic     fr_valid;
  logic     fr_ready;
  seg_buf_t fr_data;
  logic     q_valid;
  logic     q_ready;
  seg_buf_t q_data;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_layout_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      colon_layout_r <= cfg_colon_layout;
    end
  end

  // Request decode and formatting.
  ssff_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .colon_layout   (colon_layout_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_number      (in_number),
    .in_first_pair  (in_first_pair),
    .in_second_pair (in_second_pair),
    .res_valid      (fr_valid),
    .res_ready      (fr_ready),
    .res_data       (fr_data)
  );

  // Queue of formatted buffers.
  ssff_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Frame serializer.
  ssff_back #(
    .DISPLAY_BYTES (DISPLAY_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_data         (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for seven_segment_frame_formatter_unit: sends display requests and
// checks every byte of each 17-byte frame against a built-in formatter model.
// Depends on ssff_pkg for the mode codes and segment constants.
module tb;
  import ssff_pkg::*;

  localparam int DISPLAY_BYTES = 8;
  localparam int FRAME_LEN     = 1 + 2 * DISPLAY_BYTES;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 32;

  typedef logic [DISPLAY_BYTES-1:0][7:0] display_ram_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } frame_beat_t;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               cfg_valid        = 1'b0;
  logic               cfg_ready;
  logic               cfg_colon_layout = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func          = FUNC_INT;
  logic signed [31:0] in_number        = '0;
  logic [7:0]         in_first_pair    = '0;
  logic [7:0]         in_second_pair   = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last;

  // Frame bytes still owed by the block, oldest first.
  frame_beat_t pending_frame_bytes[$];
  bit          colon_layout_model = 1'b0;
  int          send_idle_pct      = 0;
  int          recv_stall_pct     = 0;
  int          mismatch_count     = 0;
  int          cycle_count        = 0;

  seven_segment_frame_formatter_unit #(
    .DISPLAY_BYTES(DISPLAY_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_colon_layout(cfg_colon_layout),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_number       (in_number),
    .in_first_pair   (in_first_pair),
    .in_second_pair  (in_second_pair),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_byte  (out_frame_byte),
    .out_last        (out_last)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random according to the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Maps an ASCII character to its segment pattern; unknown ones are blank.
  function automatic seg_t char_segments(input logic [7:0] c);
    case (c)
      ".":     return SEG_DOT;
      ":":     return SEG_COLON;
      "-":     return SEG_MINUS;
      "0":     return 8'h3F;
      "1":     return 8'h06;
      "2":     return 8'h5B;
      "3":     return 8'h4F;
      "4":     return 8'h66;
      "5":     return 8'h6D;
      "6":     return 8'h7D;
      "7":     return 8'h07;
      "8":     return 8'h7F;
      "9":     return 8'h6F;
      "A":     return 8'h77;
      "B":     return 8'h7C;
      "C":     return 8'h39;
      "D":     return 8'h5E;
      "E":     return 8'h79;
      "F":     return 8'h71;
      default: return SEG_BLANK;
    endcase
  endfunction

  // Builds the display RAM contents that one request produces.
  function automatic display_ram_t format_display(input logic [1:0] func,
                                                  input logic signed [31:0] number,
                                                  input logic [7:0] first_pair,
                                                  input logic [7:0] second_pair,
                                                  input bit colon);
    display_ram_t ram;
    string        text;
    logic [7:0]   chars[4];
    logic [3:0]   nib;
    int           pos;
    int           p;
    bit           is_date;
    ram = '0;
    case (func)
      FUNC_INT: begin
        // Right-justify to four characters, then keep only the first four.
        text = $sformatf("%0d", number);
        while (text.len() < 4) text = {" ", text};
        for (int i = 0; i < 4; i++) chars[i] = text[i];
      end
      FUNC_HEX: begin
        for (int i = 0; i < 4; i++) begin
          nib = number[15 - 4 * i -: 4];
          chars[i] = (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
        end
      end
      default: begin
        // Pairs above 99 produce odd tens characters that the table may blank.
        is_date = (func == FUNC_DATE);
        p = colon ? 3 : 2;
        ram[0] = char_segments(8'h30 + first_pair / 8'd10);
        ram[1] = char_segments(8'h30 + first_pair % 8'd10) | (is_date ? SEG_DOT : 8'h00);
        ram[p] = char_segments(8'h30 + second_pair / 8'd10);
        ram[p + 1] = char_segments(8'h30 + second_pair % 8'd10);
        if (colon) begin
          ram[2] = is_date ? SEG_DOT : SEG_COLON;
        end else begin
          ram[1] = ram[1] | (is_date ? SEG_DOT : SEG_COLON);
        end
      end
    endcase
    // Integer and hex text skips position 2 when the colon digit exists.
    if (!func[1]) begin
      pos = 0;
      for (int i = 0; i < 4; i++) begin
        if (colon && pos == 2) pos++;
        if (pos < DISPLAY_BYTES) ram[pos] = char_segments(chars[i]);
        pos++;
      end
    end
    return ram;
  endfunction

  // Sends one request and queues the frame it must produce.
  task automatic send_request(input logic [1:0] func, input logic signed [31:0] number,
                              input logic [7:0] first_pair, input logic [7:0] second_pair);
    display_ram_t ram;
    frame_beat_t  beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_number      <= number;
    in_first_pair  <= first_pair;
    in_second_pair <= second_pair;
    do @(posedge clk); while (!in_ready);
    ram = format_display(func, number, first_pair, second_pair, colon_layout_model);
    for (int k = 0; k < FRAME_LEN; k++) begin
      beat.frame_byte = k[0] ? ram[(k - 1) / 2] : 8'h00;
      beat.last       = (k == FRAME_LEN - 1);
      pending_frame_bytes.push_back(beat);
    end
  endtask

  // Stops sending and waits until every owed frame byte has arrived.
  task automatic wait_frames_done();
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
  endtask

  // Writes the colon layout register; only called while the block is idle.
  task automatic write_colon_layout(input bit value);
    cfg_valid        <= 1'b1;
    cfg_colon_layout <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid          <= 1'b0;
    colon_layout_model = value;
  endtask

  // Compares each accepted frame byte with the oldest one owed.
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frame_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                 $time, out_frame_byte, out_last);
        mismatch_count++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                   $time, want.frame_byte, out_frame_byte);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Edge values of every mode under the reset layout.
  task automatic test_directed();
    send_request(FUNC_INT, 0, 8'hFF, 8'hAA);
    send_request(FUNC_INT, 5, 8'h00, 8'h55);
    send_request(FUNC_INT, -7, 8'h12, 8'h34);
    send_request(FUNC_INT, 42, 8'h00, 8'h00);
    send_request(FUNC_INT, 9999, 8'h00, 8'h00);
    send_request(FUNC_INT, -999, 8'h00, 8'h00);
    send_request(FUNC_INT, 10000, 8'h00, 8'h00);
    send_request(FUNC_INT, -1000, 8'h00, 8'h00);
    send_request(FUNC_INT, -12345, 8'h00, 8'h00);
    send_request(FUNC_INT, 32'sh7FFF_FFFF, 8'h00, 8'h00);
    send_request(FUNC_INT, 32'sh8000_0000, 8'h00, 8'h00);
    send_request(FUNC_HEX, 32'sh0000_0000, 8'hFF, 8'hFF);
    send_request(FUNC_HEX, 32'shFFFF_FFFF, 8'h00, 8'h00);
    send_request(FUNC_HEX, 32'sh1234_89AB, 8'h00, 8'h00);
    send_request(FUNC_HEX, 32'sh0000_CDEF, 8'h00, 8'h00);
    send_request(FUNC_TIME, 32'shFFFF_FFFF, 8'd0, 8'd0);
    send_request(FUNC_TIME, 0, 8'd23, 8'd59);
    send_request(FUNC_TIME, 0, 8'd100, 8'd170);
    send_request(FUNC_TIME, 0, 8'd255, 8'd255);
    send_request(FUNC_DATE, 0, 8'd31, 8'd12);
    send_request(FUNC_DATE, 0, 8'd109, 8'd199);
    send_request(FUNC_DATE, 0, 8'd220, 8'd0);
    wait_frames_done();
  endtask

  // The separate colon digit moves text and pairs past position 2.
  task automatic test_colon_layout();
    write_colon_layout(1'b1);
    send_request(FUNC_INT, 1234, 8'h00, 8'h00);
    send_request(FUNC_INT, -5, 8'h00, 8'h00);
    send_request(FUNC_HEX, 32'sh0000_A5F0, 8'h00, 8'h00);
    send_request(FUNC_TIME, 0, 8'd12, 8'd34);
    send_request(FUNC_TIME, 0, 8'd100, 8'd179);
    send_request(FUNC_DATE, 0, 8'd1, 8'd1);
    send_request(FUNC_DATE, 0, 8'd255, 8'd99);
    wait_frames_done();
  endtask

  // Random requests under one layout and one pair of idle rates.
  task automatic test_random(input int count, input int sidle, input int rstall,
                             input bit colon);
    logic [1:0]         func;
    logic signed [31:0] number;
    logic [7:0]         first_pair;
    logic [7:0]         second_pair;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    write_colon_layout(colon);
    for (int i = 0; i < count; i++) begin
      func = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: number = $urandom();
        1: number = $signed($urandom_range(0, 19998)) - 9999;
        2: number = $signed($urandom_range(0, 199998)) - 99999;
        default: number = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 15)
                                                : 32'sh8000_0000 + $urandom_range(0, 15);
      endcase
      // Mostly valid clock and calendar values, sometimes anything.
      first_pair  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 99))
                                               : 8'($urandom_range(0, 255));
      second_pair = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 99))
                                               : 8'($urandom_range(0, 255));
      send_request(func, number, first_pair, second_pair);
    end
    wait_frames_done();
  endtask

  // Test sequence.
  initial begin
    send_idle_pct  = 29;
    recv_stall_pct = 71;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_colon_layout();
    test_random(30, 29, 71, 1'b0);
    test_random(30, 71, 29, 1'b1);
    test_random(30, 0, 0, 1'($urandom_range(0, 1)));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
